// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SPJQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("spjq assertion failed");

// Check that a condition in a cycle implies another in the same cycle.
`define SPJQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spjq implication failed");

`endif

// File: rtl/core/spjq_pkg.sv
// Package for the sorted priority job queue: command and status codes,
// the control struct that drives the cell chain. No dependencies.
package spjq_pkg;

   localparam int IdWidth   = 16;
   localparam int PriWidth  = 8;
   localparam int CountOutW = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic insert_en;
      logic remove_en;
   } spjq_ctrl_type;

endpackage

// File: rtl/core/spjq_cell.sv
// One cell of the sorted queue chain: holds one job and shifts with its neighbors.
// Depends on spjq_pkg.
module spjq_cell #(
   parameter int IDX     = 0,
   parameter int COUNT_W = 5
) (
   input  logic                              clock,
   input  spjq_pkg::spjq_ctrl_type           ctrl,
   input  logic [COUNT_W-1:0]                count,
   input  logic [spjq_pkg::IdWidth-1:0]      new_id,
   input  logic [spjq_pkg::PriWidth-1:0]     new_pri,
   input  logic                              prev_greater,
   input  logic [spjq_pkg::IdWidth-1:0]      prev_id,
   input  logic [spjq_pkg::PriWidth-1:0]     prev_pri,
   input  logic [spjq_pkg::IdWidth-1:0]      next_id,
   input  logic [spjq_pkg::PriWidth-1:0]     next_pri,
   output logic                              greater,
   output logic [spjq_pkg::IdWidth-1:0]      id,
   output logic [spjq_pkg::PriWidth-1:0]     pri
);
   import spjq_pkg::*;

   localparam logic [COUNT_W-1:0] IDX_C = COUNT_W'(IDX);

   logic [IdWidth-1:0]  id_ff,  id_in;
   logic [PriWidth-1:0] pri_ff, pri_in;
   logic                occupied;

   assign occupied = IDX_C < count;
   assign greater  = occupied && (pri_ff > new_pri);

   always_comb begin
      id_in  = id_ff;
      pri_in = pri_ff;
      if (ctrl.insert_en) begin
         if (prev_greater) begin
            // make room: take the neighbor's job
            id_in  = prev_id;
            pri_in = prev_pri;
         end else if (greater || (count == IDX_C)) begin
            id_in  = new_id;
            pri_in = new_pri;
         end
      end else if (ctrl.remove_en) begin
         id_in  = next_id;
         pri_in = next_pri;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      pri_ff <= pri_in;
   end

   assign id  = id_ff;
   assign pri = pri_ff;

endmodule

// File: rtl/core/sorted_priority_job_queue.sv
// Sorted priority job queue, top level: live count, output register, cell chain.
// Depends on spjq_pkg and spjq_cell.
//
// Holds up to DEPTH jobs (id, priority) in a chain of cells kept in ascending
// priority order, head in cell zero. An insert drops the new job behind every
// job of smaller or equal priority, so equal priorities leave in arrival order;
// a remove hands back the head job and moves the rest up one cell. Every item
// gets exactly one result with status, the removed job (zero unless a remove
// succeeded) and the live count after the item, masked to five bits. For each
// item all cells compare against the new priority and shift in parallel at the
// clock edge that takes it, and the result appears in the output register on
// the following cycle. A new item is taken every cycle as long as the output
// register is empty or its result is being taken in the same cycle. Entries
// hold no reset value; only live cells are ever read.
module sorted_priority_job_queue #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [spjq_pkg::IdWidth-1:0]      req_job_id,
   input  logic [spjq_pkg::PriWidth-1:0]     req_job_priority,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [spjq_pkg::IdWidth-1:0]      rsp_removed_id,
   output logic [spjq_pkg::PriWidth-1:0]     rsp_removed_priority,
   output logic [spjq_pkg::CountOutW-1:0]    rsp_job_count
);
   import spjq_pkg::*;

   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [COUNT_W-1:0] FULL_C = COUNT_W'(DEPTH);

   // live count
   logic [COUNT_W-1:0] count_ff, count_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [IdWidth-1:0]    rid_ff, rid_in;
   logic [PriWidth-1:0]   rpri_ff, rpri_in;
   logic [COUNT_W-1:0]    rcount_ff;

   logic                  accept;
   logic                  full;
   logic                  empty;
   spjq_ctrl_type         ctrl;

   // chain wires
   logic                  cell_greater [DEPTH];
   logic [IdWidth-1:0]    cell_id      [DEPTH];
   logic [PriWidth-1:0]   cell_pri     [DEPTH];

   logic [COUNT_W+CountOutW-1:0] count_ext;

   // take a new item whenever the output register frees up this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == FULL_C);
   assign empty     = (count_ff == '0);

   assign ctrl.insert_en = accept && (req_command == CMD_INSERT) && !full;
   assign ctrl.remove_en = accept && (req_command == CMD_REMOVE) && !empty;

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      rid_in       = rid_ff;
      rpri_in      = rpri_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rid_in       = '0;
         rpri_in      = '0;
         if (req_command == CMD_INSERT) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_DONE;
               count_in  = count_ff + COUNT_W'(1);
            end
         end else begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               // hand back the head job
               status_in = STATUS_DONE;
               rid_in    = cell_id[0];
               rpri_in   = cell_pri[0];
               count_in  = count_ff - COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the output register: no reset needed
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rid_ff    <= rid_in;
      rpri_ff   <= rpri_in;
      if (accept) begin
         rcount_ff <= count_in;
      end
   end

   // cell chain: each inner cell sees its neighbors on both sides
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                prev_greater;
      logic [IdWidth-1:0]  prev_id;
      logic [PriWidth-1:0] prev_pri;
      logic [IdWidth-1:0]  next_id;
      logic [PriWidth-1:0] next_pri;

      if (i == 0) begin : g_head
         assign prev_greater = 1'b0;
         assign prev_id      = '0;
         assign prev_pri     = '0;
      end else begin : g_body
         assign prev_greater = cell_greater[i-1];
         assign prev_id      = cell_id[i-1];
         assign prev_pri     = cell_pri[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         // hold the tail's own job on remove; it falls out of the live range
         assign next_id  = cell_id[i];
         assign next_pri = cell_pri[i];
      end else begin : g_link
         assign next_id  = cell_id[i+1];
         assign next_pri = cell_pri[i+1];
      end

      spjq_cell #(
         .IDX     (i),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .count        (count_ff),
         .new_id       (req_job_id),
         .new_pri      (req_job_priority),
         .prev_greater (prev_greater),
         .prev_id      (prev_id),
         .prev_pri     (prev_pri),
         .next_id      (next_id),
         .next_pri     (next_pri),
         .greater      (cell_greater[i]),
         .id           (cell_id[i]),
         .pri          (cell_pri[i])
      );
   end

   // report the count masked to five bits
   assign count_ext = {{CountOutW{1'b0}}, rcount_ff};

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_id       = rid_ff;
   assign rsp_removed_priority = rpri_ff;
   assign rsp_job_count        = count_ext[CountOutW-1:0];

endmodule

// File: rtl/core/spjq_checker.sv
// Port-level checker for the sorted priority job queue, bound to the top level.
// Depends on spjq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spjq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_command,
   input logic [spjq_pkg::IdWidth-1:0]      req_job_id,
   input logic [spjq_pkg::PriWidth-1:0]     req_job_priority,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [1:0]                        rsp_status,
   input logic [spjq_pkg::IdWidth-1:0]      rsp_removed_id,
   input logic [spjq_pkg::PriWidth-1:0]     rsp_removed_priority,
   input logic [spjq_pkg::CountOutW-1:0]    rsp_job_count
);
   import spjq_pkg::*;

   logic req_fire;
   logic unused_ok;

   assign req_fire  = req_valid && req_ready;
   assign unused_ok = req_command ^ (^req_job_id) ^ (^req_job_priority);

   // every accepted item shows its result in the next cycle
   `SPJQ_ASSERT(a_result_follows, clock, reset, req_fire |=> rsp_valid)

   // a pending result stays until taken
   `SPJQ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // an empty output register never blocks the input
   `SPJQ_ASSERT_IMPLY(a_ready_when_idle, clock, reset, !rsp_valid, req_ready)

   // a refused item carries no removed job
   `SPJQ_ASSERT_IMPLY(a_refused_zero, clock, reset,
      rsp_valid && (rsp_status != STATUS_DONE) && (unused_ok || !unused_ok),
      (rsp_removed_id == '0) && (rsp_removed_priority == '0))

   // an empty queue reports a zero count
   `SPJQ_ASSERT_IMPLY(a_empty_count, clock, reset,
      rsp_valid && (rsp_status == STATUS_EMPTY), rsp_job_count == '0)

endmodule

bind sorted_priority_job_queue spjq_checker u_spjq_checker (.*);

// File: sim/tb_sorted_priority_job_queue.sv
// Testbench for the sorted priority job queue: directed table, then random
// insert/remove phases, each result checked against a software copy of the
// queue or a hand-typed value. Depends on spjq_pkg and the sorted_priority_job_queue RTL.
`timescale 1ns / 1ps

module tb_sorted_priority_job_queue;
   import spjq_pkg::*;

   localparam int QDepth      = 16;
   localparam int RandomItems = 525;
   localparam int HoldCycles  = 90;
   localparam int MaxReports  = 10;

   // One result item as the block reports it.
   typedef struct packed {
      status_type                status;
      logic [IdWidth-1:0]        removed_id;
      logic [PriWidth-1:0]       removed_priority;
      logic [CountOutW-1:0]      job_count;
   } job_result_type;

   // One row of the directed table; fixed_valid marks rows whose result is
   // typed in by hand instead of taken from the queue copy.
   typedef struct {
      logic                      command;
      logic [IdWidth-1:0]        job_id;
      logic [PriWidth-1:0]       job_priority;
      bit                        fixed_valid;
      job_result_type            fixed;
   } job_row_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic                   req_command      = CMD_INSERT;
   logic [IdWidth-1:0]     req_job_id       = '0;
   logic [PriWidth-1:0]    req_job_priority = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [1:0]             rsp_status;
   logic [IdWidth-1:0]     rsp_removed_id;
   logic [PriWidth-1:0]    rsp_removed_priority;
   logic [CountOutW-1:0]   rsp_job_count;

   // Software copy of the queue: ids and priorities in service order.
   logic [IdWidth-1:0]     held_id  [QDepth];
   logic [PriWidth-1:0]    held_pri [QDepth];
   int                     held_count = 0;

   job_result_type         awaited_results[$];
   job_row_type            directed_rows[$];
   int                     error_count = 0;

   // Shared between the sender and the receiver: gaps on/off and a request
   // for one long receiver hold-off.
   bit                     gaps_enabled = 1'b1;
   bit                     hold_request = 1'b0;

   sorted_priority_job_queue #(
      .DEPTH(QDepth)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_job_id           (req_job_id),
      .req_job_priority     (req_job_priority),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_removed_id       (rsp_removed_id),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_job_count        (rsp_job_count)
   );

   always #6 clock = ~clock;

   // Apply one command to the queue copy and work out the result item.
   // Insert goes behind every job of smaller or equal priority; remove takes
   // the head. Full and empty leave the queue untouched.
   task automatic apply_job_command(input logic cmd, input logic [IdWidth-1:0] id,
                                    input logic [PriWidth-1:0] pri,
                                    output job_result_type res);
      int pos;
      int k;
      res.status           = STATUS_DONE;
      res.removed_id       = '0;
      res.removed_priority = '0;
      if (cmd == CMD_INSERT) begin
         if (held_count >= QDepth) begin
            res.status = STATUS_FULL;
         end else begin
            pos = held_count;
            while (pos > 0 && held_pri[pos-1] > pri) begin
               held_id[pos]  = held_id[pos-1];
               held_pri[pos] = held_pri[pos-1];
               pos--;
            end
            held_id[pos]  = id;
            held_pri[pos] = pri;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.removed_id       = held_id[0];
            res.removed_priority = held_pri[0];
            for (k = 1; k < held_count; k++) begin
               held_id[k-1]  = held_id[k];
               held_pri[k-1] = held_pri[k];
            end
            held_count--;
         end
      end
      res.job_count = held_count[CountOutW-1:0];
   endtask

   // Offer one item from a falling edge, with optional random gaps before it.
   // Valid stays high until the item is taken; then predict its result and
   // return at the next falling edge.
   task automatic offer_job(input logic cmd, input logic [IdWidth-1:0] id,
                            input logic [PriWidth-1:0] pri,
                            input bit fixed_valid, input job_result_type fixed);
      job_result_type predicted;
      while (gaps_enabled && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_job_id       <= id;
      req_job_priority <= pri;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_job_command(cmd, id, pri, predicted);
      awaited_results.push_back(fixed_valid ? fixed : predicted);
      @(negedge clock);
   endtask

   function automatic void add_row(input logic cmd, input logic [IdWidth-1:0] id,
                                   input logic [PriWidth-1:0] pri,
                                   input bit fixed_valid, input status_type st,
                                   input logic [IdWidth-1:0] rid,
                                   input logic [PriWidth-1:0] rpri,
                                   input logic [CountOutW-1:0] cnt);
      job_row_type row;
      row.command                = cmd;
      row.job_id                 = id;
      row.job_priority           = pri;
      row.fixed_valid            = fixed_valid;
      row.fixed.status           = st;
      row.fixed.removed_id       = rid;
      row.fixed.removed_priority = rpri;
      row.fixed.job_count        = cnt;
      directed_rows.push_back(row);
   endfunction

   // Receiver: random stalls, plus one long hold-off when the sender asks for
   // it. The hold-off is counted here so the sender keeps pushing meanwhile.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HoldCycles;
            rsp_ready   <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(gaps_enabled && $urandom_range(0, 99) < 15);
         end
      end
   end

   // Checker: every result item taken is matched against the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      job_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            if (error_count < MaxReports)
               $display("[%0t] result with nothing awaited: status=%0d id=%h pri=%h count=%0d",
                        $realtime, rsp_status, rsp_removed_id, rsp_removed_priority,
                        rsp_job_count);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status || rsp_removed_id !== want.removed_id ||
                rsp_removed_priority !== want.removed_priority ||
                rsp_job_count !== want.job_count) begin
               if (error_count < MaxReports) begin
                  $write("[%0t] mismatch: expected status=%0d id=%h pri=%h count=%0d,",
                         $realtime, want.status, want.removed_id, want.removed_priority,
                         want.job_count);
                  $display(" got status=%0d id=%h pri=%h count=%0d",
                           rsp_status, rsp_removed_id, rsp_removed_priority,
                           rsp_job_count);
               end
               error_count++;
            end
         end
      end
   end

   // Hard stop in case the handshake hangs.
   initial begin
      #3_000_000;
      $display("sorted_priority_job_queue verification failed");
      $finish;
   end

   initial begin
      job_result_type no_fixed;
      job_row_type row;
      int          sent;
      int          phase;
      int          phase_len;
      int          insert_pct;
      int          pri_mode;
      int          i;
      logic        cmd;
      logic [PriWidth-1:0] pri;

      no_fixed = '0;

      // Directed table. Hand-typed results: empty remove right after reset
      // (with junk in the ignored fields), extremes of id and priority, a tie
      // at priority zero that must leave in arrival order, drain to empty.
      add_row(CMD_REMOVE, 16'hABCD, 8'h5A, 1, STATUS_EMPTY, 16'h0000, 8'h00, 5'd0);
      add_row(CMD_INSERT, 16'hFFFF, 8'hFF, 1, STATUS_DONE,  16'h0000, 8'h00, 5'd1);
      add_row(CMD_INSERT, 16'h0000, 8'h00, 1, STATUS_DONE,  16'h0000, 8'h00, 5'd2);
      add_row(CMD_INSERT, 16'h1234, 8'h00, 1, STATUS_DONE,  16'h0000, 8'h00, 5'd3);
      add_row(CMD_REMOVE, 16'hFFFF, 8'hFF, 1, STATUS_DONE,  16'h0000, 8'h00, 5'd2);
      add_row(CMD_REMOVE, 16'h0000, 8'h00, 1, STATUS_DONE,  16'h1234, 8'h00, 5'd1);
      add_row(CMD_REMOVE, 16'h5555, 8'hAA, 1, STATUS_DONE,  16'hFFFF, 8'hFF, 5'd0);
      add_row(CMD_REMOVE, 16'hFFFF, 8'hFF, 1, STATUS_EMPTY, 16'h0000, 8'h00, 5'd0);
      // Fill to capacity with four repeated priorities in mixed order, so
      // ties land in the middle of the chain; these go through the predictor.
      for (i = 0; i < QDepth; i++)
         add_row(CMD_INSERT, 16'h0100 + i[15:0], {i[0], i[1], 6'h00}, 0,
                 STATUS_DONE, '0, '0, '0);
      // Insert into a full queue is refused and leaves the count at capacity.
      add_row(CMD_INSERT, 16'h7777, 8'h01, 1, STATUS_FULL, 16'h0000, 8'h00, 5'd16);

      // Hold reset, then release it at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table.
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         offer_job(row.command, row.job_id, row.job_priority, row.fixed_valid, row.fixed);
      end

      // Random phases: fill-heavy, drain-heavy or balanced, with the priority
      // drawn from the full range, a narrow band (many ties) or the extremes.
      sent  = 0;
      phase = 0;
      while (sent < RandomItems) begin
         phase_len = $urandom_range(20, 45);
         case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 15;
            default: insert_pct = 55;
         endcase
         pri_mode = $urandom_range(0, 2);
         // Third phase: long receiver hold-off while inserts keep coming,
         // so the output register fills and the input stalls.
         if (phase == 2) begin
            hold_request = 1'b1;
            insert_pct   = 85;
         end
         // Fifth phase: a quiet stretch with no gaps on either side.
         gaps_enabled = (phase != 4);
         for (i = 0; i < phase_len && sent < RandomItems; i++) begin
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            case (pri_mode)
               0:       pri = PriWidth'($urandom_range(0, 255));
               1:       pri = PriWidth'($urandom_range(0, 3));
               default: pri = $urandom_range(0, 1) ?
                                 PriWidth'(8'hFF - $urandom_range(0, 1)) :
                                 PriWidth'($urandom_range(0, 1));
            endcase
            offer_job(cmd, IdWidth'($urandom_range(0, 65535)), pri, 0, no_fixed);
            sent++;
         end
         phase++;
      end
      gaps_enabled = 1'b1;
      req_valid   <= 1'b0;

      // Drain: wait for every awaited result, then keep watching the output so a
      // stray extra result would still be caught.
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("sorted_priority_job_queue verification clean");
      else
         $display("sorted_priority_job_queue verification failed");
      $finish;
   end

endmodule
